>>> src/qrs_pkg.sv
// qrs_pkg: widths, result codes and shared types for the quadratic root solver.
// No dependencies; imported by every qrs_* module and the top level.
`timescale 1ns / 1ps
package qrs_pkg;
   localparam int COEF_W  = 32;               // coefficient / root width
   localparam int FRAC_W  = 16;               // fraction bits
   localparam int PROD_W  = 2 * COEF_W;       // unsigned product width
   localparam int DISC_W  = 2 * COEF_W + 1;   // discriminant width
   localparam int ROOT_W  = COEF_W + 1;       // isqrt result width
   localparam int SQ_REM_W = ROOT_W + 2;      // isqrt partial remainder
   localparam int NUM_W   = COEF_W + 3;       // signed numerator width
   localparam int NMAG_W  = NUM_W - 1;        // numerator magnitude width
   localparam int DEN_W   = COEF_W + 1;       // denominator magnitude width
   localparam int QUO_W   = NMAG_W + FRAC_W;  // quotient width / divider stages

   localparam logic [1:0] CNT_NONE     = 2'd0;
   localparam logic [1:0] CNT_ONE      = 2'd1;
   localparam logic [1:0] CNT_TWO      = 2'd2;
   localparam logic [1:0] CNT_INFINITE = 2'd3;

   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
      logic a_zero;
      logic b_zero;
      logic c_zero;
      logic dneg;
   } sq_tag_type;

   typedef struct packed {
      logic [1:0] count;
      logic neg_plus;
      logic neg_minus;
   } dv_tag_type;
endpackage

>>> src/qrs_front.sv
// qrs_front: coefficient magnitudes, b*b and a*c products, then the exact discriminant.
// Two register stages. Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [qrs_pkg::COEF_W-1:0] in_a,
   input  logic signed [qrs_pkg::COEF_W-1:0] in_b,
   input  logic signed [qrs_pkg::COEF_W-1:0] in_c,
   output logic                          out_valid,
   output logic [qrs_pkg::DISC_W-1:0]    out_d,
   output qrs_pkg::sq_tag_type           out_tag
);
   import qrs_pkg::*;

   logic                     s1_valid_ff;
   logic [PROD_W-1:0]        s1_bb_ff, s1_ac_ff;
   logic signed [COEF_W-1:0] s1_a_ff, s1_b_ff, s1_c_ff;
   logic [COEF_W-1:0]        mag_a, mag_b, mag_c;

   logic                     s2_valid_ff;
   logic [DISC_W-1:0]        s2_d_ff, s2_d_in;
   sq_tag_type               s2_tag_ff, s2_tag_in;
   logic [DISC_W:0]          bb_x, ac4_x;
   logic                     ac_neg;

   assign mag_a = in_a[COEF_W-1] ? (~in_a + 1'b1) : in_a;
   assign mag_b = in_b[COEF_W-1] ? (~in_b + 1'b1) : in_b;
   assign mag_c = in_c[COEF_W-1] ? (~in_c + 1'b1) : in_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_bb_ff  <= mag_b * mag_b;
         s1_ac_ff  <= mag_a * mag_c;
         s1_a_ff   <= in_a;
         s1_b_ff   <= in_b;
         s1_c_ff   <= in_c;
         s2_d_ff   <= s2_d_in;
         s2_tag_ff <= s2_tag_in;
      end
   end

   always_comb begin
      bb_x   = {{(DISC_W+1-PROD_W){1'b0}}, s1_bb_ff};
      ac4_x  = {s1_ac_ff, 2'b00};
      ac_neg = (s1_a_ff[COEF_W-1] != s1_c_ff[COEF_W-1]) && (s1_c_ff != '0);
      s2_tag_in.a      = s1_a_ff;
      s2_tag_in.b      = s1_b_ff;
      s2_tag_in.c      = s1_c_ff;
      s2_tag_in.a_zero = (s1_a_ff == '0);
      s2_tag_in.b_zero = (s1_b_ff == '0);
      s2_tag_in.c_zero = (s1_c_ff == '0);
      s2_tag_in.dneg   = 1'b0;
      s2_d_in          = '0;
      if (ac_neg) begin
         s2_d_in = DISC_W'(bb_x + ac4_x);
      end else if (bb_x >= ac4_x) begin
         s2_d_in = DISC_W'(bb_x - ac4_x);
      end else begin
         s2_tag_in.dneg = 1'b1;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_d     = s2_d_ff;
   assign out_tag   = s2_tag_ff;
endmodule

>>> src/qrs_isqrt.sv
// qrs_isqrt: pipelined digit-by-digit integer square root, one result bit per stage.
// Carries a sideband tag alongside. Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [qrs_pkg::DISC_W-1:0] in_d,
   input  qrs_pkg::sq_tag_type        in_tag,
   output logic                       out_valid,
   output logic [qrs_pkg::ROOT_W-1:0] out_root,
   output qrs_pkg::sq_tag_type        out_tag
);
   import qrs_pkg::*;

   localparam int PAD_W = 2 * ROOT_W;

   logic                valid_ff [ROOT_W];
   logic [PAD_W-1:0]    d_ff     [ROOT_W];
   logic [SQ_REM_W-1:0] rem_ff   [ROOT_W];
   logic [ROOT_W-1:0]   root_ff  [ROOT_W];
   sq_tag_type          tag_ff   [ROOT_W];

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_stage
         logic                valid_prev;
         logic [PAD_W-1:0]    d_prev;
         logic [SQ_REM_W-1:0] rem_prev, rem_in;
         logic [ROOT_W-1:0]   root_prev, root_in;
         sq_tag_type          tag_prev;
         logic [SQ_REM_W+1:0] trial, test;

         if (k == 0) begin : g_first
            assign valid_prev = in_valid;
            assign d_prev     = {{(PAD_W-DISC_W){1'b0}}, in_d};
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign tag_prev   = in_tag;
         end else begin : g_next
            assign valid_prev = valid_ff[k-1];
            assign d_prev     = d_ff[k-1];
            assign rem_prev   = rem_ff[k-1];
            assign root_prev  = root_ff[k-1];
            assign tag_prev   = tag_ff[k-1];
         end

         always_comb begin
            trial = {rem_prev, d_prev[PAD_W-1-2*k -: 2]};
            test  = {2'b00, root_prev, 2'b01};
            if (trial >= test) begin
               rem_in  = SQ_REM_W'(trial - test);
               root_in = {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = SQ_REM_W'(trial);
               root_in = {root_prev[ROOT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en) begin
               valid_ff[k] <= valid_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               d_ff[k]    <= d_prev;
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
               tag_ff[k]  <= tag_prev;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];
endmodule

>>> src/qrs_div.sv
// qrs_div: two-lane pipelined restoring divider sharing one denominator,
// one quotient bit per stage. Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [qrs_pkg::NMAG_W-1:0] in_num_plus,
   input  logic [qrs_pkg::NMAG_W-1:0] in_num_minus,
   input  logic [qrs_pkg::DEN_W-1:0]  in_den,
   input  qrs_pkg::dv_tag_type        in_tag,
   output logic                       out_valid,
   output logic [qrs_pkg::QUO_W-1:0]  out_quo_plus,
   output logic [qrs_pkg::QUO_W-1:0]  out_quo_minus,
   output qrs_pkg::dv_tag_type        out_tag
);
   import qrs_pkg::*;

   logic              valid_ff [QUO_W];
   logic [QUO_W-1:0]  nump_ff  [QUO_W];
   logic [QUO_W-1:0]  numm_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [DEN_W-1:0]  remp_ff  [QUO_W];
   logic [DEN_W-1:0]  remm_ff  [QUO_W];
   logic [QUO_W-1:0]  quop_ff  [QUO_W];
   logic [QUO_W-1:0]  quom_ff  [QUO_W];
   dv_tag_type        tag_ff   [QUO_W];

   genvar k;
   generate
      for (k = 0; k < QUO_W; k++) begin : g_stage
         logic             valid_prev;
         logic [QUO_W-1:0] nump_prev, numm_prev, quop_prev, quom_prev;
         logic [QUO_W-1:0] quop_in, quom_in;
         logic [DEN_W-1:0] den_prev, remp_prev, remm_prev, remp_in, remm_in;
         dv_tag_type       tag_prev;
         logic [DEN_W:0]   trial_p, trial_m, den_x;

         if (k == 0) begin : g_first
            assign valid_prev = in_valid;
            assign nump_prev  = {in_num_plus, {FRAC_W{1'b0}}};
            assign numm_prev  = {in_num_minus, {FRAC_W{1'b0}}};
            assign den_prev   = in_den;
            assign remp_prev  = '0;
            assign remm_prev  = '0;
            assign quop_prev  = '0;
            assign quom_prev  = '0;
            assign tag_prev   = in_tag;
         end else begin : g_next
            assign valid_prev = valid_ff[k-1];
            assign nump_prev  = nump_ff[k-1];
            assign numm_prev  = numm_ff[k-1];
            assign den_prev   = den_ff[k-1];
            assign remp_prev  = remp_ff[k-1];
            assign remm_prev  = remm_ff[k-1];
            assign quop_prev  = quop_ff[k-1];
            assign quom_prev  = quom_ff[k-1];
            assign tag_prev   = tag_ff[k-1];
         end

         always_comb begin
            den_x   = {1'b0, den_prev};
            trial_p = {remp_prev, nump_prev[QUO_W-1-k]};
            trial_m = {remm_prev, numm_prev[QUO_W-1-k]};
            quop_in = quop_prev;
            quom_in = quom_prev;
            if (trial_p >= den_x) begin
               remp_in = DEN_W'(trial_p - den_x);
               quop_in[QUO_W-1-k] = 1'b1;
            end else begin
               remp_in = DEN_W'(trial_p);
            end
            if (trial_m >= den_x) begin
               remm_in = DEN_W'(trial_m - den_x);
               quom_in[QUO_W-1-k] = 1'b1;
            end else begin
               remm_in = DEN_W'(trial_m);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en) begin
               valid_ff[k] <= valid_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               nump_ff[k] <= nump_prev;
               numm_ff[k] <= numm_prev;
               den_ff[k]  <= den_prev;
               remp_ff[k] <= remp_in;
               remm_ff[k] <= remm_in;
               quop_ff[k] <= quop_in;
               quom_ff[k] <= quom_in;
               tag_ff[k]  <= tag_prev;
            end
         end
      end
   endgenerate

   assign out_valid     = valid_ff[QUO_W-1];
   assign out_quo_plus  = quop_ff[QUO_W-1];
   assign out_quo_minus = quom_ff[QUO_W-1];
   assign out_tag       = tag_ff[QUO_W-1];
endmodule

>>> src/quadratic_root_solver_top.sv
// quadratic_root_solver_top: real roots of a*x^2+b*x+c=0, Q16.16 in and out.
// Register stages: 2 front (multiply, discriminant), 33 isqrt, 1 setup, 50 divide, 1 output.
// Throughput one transaction per cycle; the whole pipe holds while the output register is stalled.
// Reset (synchronous, active high) clears every stage valid bit; data registers are not reset.
`timescale 1ns / 1ps
module quadratic_root_solver_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_c,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_root_count,
   output logic signed [qrs_pkg::COEF_W-1:0] rsp_root_plus,
   output logic signed [qrs_pkg::COEF_W-1:0] rsp_root_minus,
   output logic                              rsp_saturated
);
   import qrs_pkg::*;

   // Single pipeline enable: everything advances unless a result sits stalled.
   logic rsp_valid_ff;
   logic adv;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Front end: products and discriminant.
   logic              fr_valid;
   logic [DISC_W-1:0] fr_d;
   sq_tag_type        fr_tag;

   qrs_front u_front (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(req_valid), .in_a(req_coef_a), .in_b(req_coef_b), .in_c(req_coef_c),
      .out_valid(fr_valid), .out_d(fr_d), .out_tag(fr_tag)
   );

   // Integer square root of the discriminant.
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   sq_tag_type        sq_tag;

   qrs_isqrt u_isqrt (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(fr_valid), .in_d(fr_d), .in_tag(fr_tag),
      .out_valid(sq_valid), .out_root(sq_root), .out_tag(sq_tag)
   );

   // Setup stage: numerators, denominator and root-count code.
   // A zero discriminant gives a zero root, so the double root falls out of
   // the general numerators. Linear case divides -c by b in both lanes.
   logic                    su_valid_ff;
   logic [NMAG_W-1:0]       su_nump_ff, su_nump_in, su_numm_ff, su_numm_in;
   logic [DEN_W-1:0]        su_den_ff, su_den_in;
   dv_tag_type              su_tag_ff, su_tag_in;
   logic signed [NUM_W-1:0] nb, sx, nc, n_p, n_m;
   logic signed [DEN_W:0]   den_s;

   always_comb begin
      nb  = -NUM_W'(sq_tag.b);
      nc  = -NUM_W'(sq_tag.c);
      sx  = NUM_W'({1'b0, sq_root});
      n_p = sq_tag.a_zero ? nc : NUM_W'(nb + sx);
      n_m = sq_tag.a_zero ? nc : NUM_W'(nb - sx);
      den_s = sq_tag.a_zero ? (DEN_W+1)'(sq_tag.b)
                            : {sq_tag.a[COEF_W-1], sq_tag.a, 1'b0};
      su_nump_in = n_p[NUM_W-1] ? NMAG_W'(-n_p) : NMAG_W'(n_p);
      su_numm_in = n_m[NUM_W-1] ? NMAG_W'(-n_m) : NMAG_W'(n_m);
      su_den_in  = den_s[DEN_W] ? DEN_W'(-den_s) : DEN_W'(den_s);
      su_tag_in.neg_plus  = n_p[NUM_W-1] != den_s[DEN_W];
      su_tag_in.neg_minus = n_m[NUM_W-1] != den_s[DEN_W];
      if (sq_tag.a_zero) begin
         if (sq_tag.b_zero) begin
            su_tag_in.count = sq_tag.c_zero ? CNT_INFINITE : CNT_NONE;
         end else begin
            su_tag_in.count = CNT_ONE;
         end
      end else if (sq_tag.dneg) begin
         su_tag_in.count = CNT_NONE;
      end else if (sq_root == '0) begin
         su_tag_in.count = CNT_ONE;
      end else begin
         su_tag_in.count = CNT_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         su_valid_ff <= 1'b0;
      end else if (adv) begin
         su_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         su_nump_ff <= su_nump_in;
         su_numm_ff <= su_numm_in;
         su_den_ff  <= su_den_in;
         su_tag_ff  <= su_tag_in;
      end
   end

   // Two-lane divider; a zero denominator only occurs when the roots are
   // suppressed below, so its quotient is never used.
   logic             dv_valid;
   logic [QUO_W-1:0] dv_qp, dv_qm;
   dv_tag_type       dv_tag;

   qrs_div u_div (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(su_valid_ff), .in_num_plus(su_nump_ff), .in_num_minus(su_numm_ff),
      .in_den(su_den_ff), .in_tag(su_tag_ff),
      .out_valid(dv_valid), .out_quo_plus(dv_qp), .out_quo_minus(dv_qm), .out_tag(dv_tag)
   );

   // Output stage: clamp, apply sign, blank absent roots.
   localparam logic [QUO_W-1:0] LIM_POS = QUO_W'({1'b0, {(COEF_W-1){1'b1}}});
   localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'({1'b1, {(COEF_W-1){1'b0}}});

   logic [1:0]               rsp_count_ff;
   logic signed [COEF_W-1:0] rsp_plus_ff, rsp_plus_in, rsp_minus_ff, rsp_minus_in;
   logic                     rsp_sat_ff, rsp_sat_in;
   logic                     sat_p, sat_m, roots_on;
   logic [COEF_W-1:0]        mp, mm;

   always_comb begin
      roots_on = (dv_tag.count == CNT_ONE) || (dv_tag.count == CNT_TWO);
      sat_p = dv_tag.neg_plus  ? (dv_qp > LIM_NEG) : (dv_qp > LIM_POS);
      sat_m = dv_tag.neg_minus ? (dv_qm > LIM_NEG) : (dv_qm > LIM_POS);
      mp = sat_p ? (dv_tag.neg_plus  ? COEF_W'(LIM_NEG) : COEF_W'(LIM_POS)) : dv_qp[COEF_W-1:0];
      mm = sat_m ? (dv_tag.neg_minus ? COEF_W'(LIM_NEG) : COEF_W'(LIM_POS)) : dv_qm[COEF_W-1:0];
      rsp_plus_in  = roots_on ? (dv_tag.neg_plus  ? -mp : mp) : '0;
      rsp_minus_in = roots_on ? (dv_tag.neg_minus ? -mm : mm) : '0;
      rsp_sat_in   = roots_on && (sat_p || sat_m);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_count_ff <= dv_tag.count;
         rsp_plus_ff  <= rsp_plus_in;
         rsp_minus_ff <= rsp_minus_in;
         rsp_sat_ff   <= rsp_sat_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_root_count = rsp_count_ff;
   assign rsp_root_plus  = rsp_plus_ff;
   assign rsp_root_minus = rsp_minus_ff;
   assign rsp_saturated  = rsp_sat_ff;

   // Absent roots read as zero with no saturation.
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_count == CNT_NONE || rsp_root_count == CNT_INFINITE)
      |-> (rsp_root_plus == '0 && rsp_root_minus == '0 && !rsp_saturated))
      else $error("absent roots not blanked");

   // A single root appears identically in both lanes.
   a_single_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_count == CNT_ONE |-> rsp_root_plus == rsp_root_minus)
      else $error("single root differs between lanes");

   // Input back-pressure only while a result waits.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output stall");
endmodule
